[rtl/ebt_pkg.sv]
// Package: types and constants for the emit budget tracker.
package ebt_pkg;

   localparam int BATCH_SLOTS = 16;
   localparam int SLOT_W      = $clog2(BATCH_SLOTS);
   localparam int OCC_W       = $clog2(BATCH_SLOTS + 1);

   localparam logic [1:0] MODE_REQUEST = 2'd0;
   localparam logic [1:0] MODE_AGE     = 2'd1;
   localparam logic [1:0] MODE_FRAME   = 2'd2;

   localparam logic [2:0] REG_MAX_PARTICLES = 3'd0;
   localparam logic [2:0] REG_LOOP_PERIOD   = 3'd1;
   localparam logic [2:0] REG_LOOP_COUNT    = 3'd2;
   localparam logic [2:0] REG_LOOP_FOREVER  = 3'd3;
   localparam logic [2:0] REG_DURATION      = 3'd4;
   localparam logic [2:0] REG_LIFETIME      = 3'd5;

   localparam logic [23:0] LIFETIME_RESET = 24'd4506;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] req_count;
      logic [19:0] delta_time;
   } req_type;

   typedef struct packed {
      logic [15:0] granted;
      logic        emit_now;
      logic [15:0] emit_amount;
      logic [23:0] loop_phase;
      logic [15:0] active_estimate;
   } rsp_type;

endpackage

[rtl/emit_budget_tracker.sv]
// Top level: emit budget tracker with a memory-based batch store.
//
// One transaction is processed at a time. A request (mode 0) is granted
// against the budget directly. Mode 3 also goes straight to the result and
// changes nothing. Aging (mode 1) walks the batch store as a ring buffer,
// reading and then writing back each occupied slot. Head retirement then
// moves the head pointer instead of shifting data, reading and checking the
// head slot for each retired batch. A frame (mode 2) runs the periodic timer
// by repeated subtraction of loop_period, one period per cycle. Each period
// issues one admission step of loop_count items, which gives the same total
// as one combined request. When there is no schedule time the timer step is
// skipped. A flush into a full store merges with the newest entry. The batch
// store is one synchronous memory of BATCH_SLOTS entries (remaining life and
// size) with a registered read. The result sits in an output register. A new
// transaction is accepted in the cycle after the previous result has been
// taken.
module emit_budget_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ebt_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ebt_pkg::rsp_type      rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import ebt_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_AGE_RD = 4'd1;
   localparam logic [3:0] S_AGE_WR = 4'd2;
   localparam logic [3:0] S_RET_RD = 4'd3;
   localparam logic [3:0] S_RET_CK = 4'd4;
   localparam logic [3:0] S_LOOP   = 4'd5;
   localparam logic [3:0] S_FLUSH  = 4'd6;
   localparam logic [3:0] S_MRG_RD = 4'd7;
   localparam logic [3:0] S_MRG_WR = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   // configuration
   logic [15:0] max_particles_ff;
   logic [23:0] loop_period_ff;
   logic [15:0] loop_count_ff;
   logic        loop_forever_ff;
   logic [23:0] duration_ff;
   logic [23:0] lifetime_ff;

   // state
   logic [3:0]        state_ff, state_in;
   logic [15:0]       pending_ff, pending_in;
   logic [15:0]       active_ff, active_in;
   logic [23:0]       timer_ff, timer_in;
   logic [23:0]       elapsed_ff, elapsed_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [OCC_W-1:0]  idx_ff, idx_in;
   logic [24:0]       tacc_ff, tacc_in;   // timer plus scheduled delta
   logic [19:0]       dt_ff, dt_in;
   logic [1:0]        mode_ff, mode_in;
   logic [15:0]       granted_ff, granted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // batch store memory
   logic [24:0]       mem_rem [BATCH_SLOTS];
   logic [15:0]       mem_size [BATCH_SLOTS];
   logic [SLOT_W-1:0] rd_addr, wr_addr;
   logic              wr_en;
   logic [24:0]       wr_rem, rd_rem_ff;
   logic [15:0]       wr_size, rd_size_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_rem[wr_addr]  <= wr_rem;
         mem_size[wr_addr] <= wr_size;
      end
      rd_rem_ff  <= mem_rem[rd_addr];
      rd_size_ff <= mem_size[rd_addr];
   end

   // configuration port
   logic       cfg_wr;
   logic [2:0] cfg_idx;
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_particles_ff <= '0;
         loop_period_ff   <= '0;
         loop_count_ff    <= '0;
         loop_forever_ff  <= 1'b1;
         duration_ff      <= '0;
         lifetime_ff      <= LIFETIME_RESET;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_MAX_PARTICLES: max_particles_ff <= csr_pwdata[15:0];
            REG_LOOP_PERIOD:   loop_period_ff   <= csr_pwdata[23:0];
            REG_LOOP_COUNT:    loop_count_ff    <= csr_pwdata[15:0];
            REG_LOOP_FOREVER:  loop_forever_ff  <= csr_pwdata[0];
            REG_DURATION:      duration_ff      <= csr_pwdata[23:0];
            REG_LIFETIME:      lifetime_ff      <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_MAX_PARTICLES: csr_prdata = {16'd0, max_particles_ff};
         REG_LOOP_PERIOD:   csr_prdata = {8'd0, loop_period_ff};
         REG_LOOP_COUNT:    csr_prdata = {16'd0, loop_count_ff};
         REG_LOOP_FOREVER:  csr_prdata = {31'd0, loop_forever_ff};
         REG_DURATION:      csr_prdata = {8'd0, duration_ff};
         REG_LIFETIME:      csr_prdata = {8'd0, lifetime_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // handshake
   logic accept;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // admission: grant against budget
   function automatic logic [15:0] grant_of(input logic [15:0] want,
                                            input logic [15:0] maxp,
                                            input logic [15:0] act,
                                            input logic [15:0] pend);
      logic [16:0] resv;
      logic [16:0] avail;
      begin
         resv  = {1'b0, act} + {1'b0, pend};
         avail = (resv < {1'b0, maxp}) ? ({1'b0, maxp} - resv) : 17'd0;
         if (maxp == 16'd0) grant_of = '0;
         else if ({1'b0, want} < avail) grant_of = want;
         else grant_of = avail[15:0];
      end
   endfunction

   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         sat_add16 = s[16] ? 16'hFFFF : s[15:0];
      end
   endfunction

   // slot address of ring position p (relative to head)
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] h,
                                                 input logic [OCC_W-1:0] p);
      logic [OCC_W:0] s;
      begin
         s = {1'b0, {(OCC_W-SLOT_W){1'b0}}, h} + {1'b0, p};
         if (s >= (OCC_W+1)'(BATCH_SLOTS)) s = s - (OCC_W+1)'(BATCH_SLOTS);
         slot_of = s[SLOT_W-1:0];
      end
   endfunction

   logic [24:0] aged;
   logic [23:0] left, sched;
   logic [15:0] g;
   logic [15:0] merged;
   logic [23:0] new_life;

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      active_in    = active_ff;
      timer_in     = timer_ff;
      elapsed_in   = elapsed_ff;
      occ_in       = occ_ff;
      head_in      = head_ff;
      idx_in       = idx_ff;
      tacc_in      = tacc_ff;
      dt_in        = dt_ff;
      mode_in      = mode_ff;
      granted_in   = granted_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_addr      = slot_of(head_ff, idx_ff);
      wr_addr      = slot_of(head_ff, idx_ff);
      wr_en        = 1'b0;
      wr_rem       = rd_rem_ff;
      wr_size      = rd_size_ff;
      aged         = (rd_rem_ff > {5'd0, dt_ff}) ? (rd_rem_ff - {5'd0, dt_ff}) : 25'd0;
      left         = (duration_ff > elapsed_ff) ? (duration_ff - elapsed_ff) : 24'd0;
      sched        = ({4'd0, dt_ff} > left) ? left : {4'd0, dt_ff};
      g            = grant_of(loop_count_ff, max_particles_ff, active_ff, pending_ff);
      merged       = sat_add16(rd_size_ff, pending_ff);
      new_life     = lifetime_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in    = req_data.mode;
               dt_in      = req_data.delta_time;
               granted_in = '0;
               idx_in     = '0;
               case (req_data.mode)
                  MODE_REQUEST: begin
                     granted_in = (req_data.req_count == 16'd0) ? 16'd0 :
                        grant_of(req_data.req_count, max_particles_ff, active_ff, pending_ff);
                     pending_in = sat_add16(pending_ff, granted_in);
                     state_in   = S_DONE;
                  end
                  MODE_AGE:   state_in = S_AGE_RD;
                  MODE_FRAME: begin
                     state_in = S_FLUSH;
                     if (loop_period_ff != 24'd0 && loop_count_ff != 16'd0) begin
                        if (!loop_forever_ff) begin
                           left  = (duration_ff > elapsed_ff) ?
                                   (duration_ff - elapsed_ff) : 24'd0;
                           sched = ({4'd0, req_data.delta_time} > left) ?
                                   left : {4'd0, req_data.delta_time};
                           elapsed_in = elapsed_ff + sched;
                        end else begin
                           sched = {4'd0, req_data.delta_time};
                        end
                        if (sched != 24'd0) begin
                           tacc_in  = {1'b0, timer_ff} + {1'b0, sched};
                           state_in = S_LOOP;
                        end
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // aging pass: read slot idx
         S_AGE_RD: begin
            if (idx_ff == occ_ff) begin
               idx_in   = '0;
               state_in = S_RET_RD;
            end else begin
               state_in = S_AGE_WR;
            end
         end
         S_AGE_WR: begin
            wr_en    = 1'b1;
            wr_rem   = aged;
            idx_in   = idx_ff + 1'b1;
            rd_addr  = slot_of(head_ff, idx_ff + 1'b1);
            state_in = S_AGE_RD;
         end
         // retirement: read the head slot, checked in the next cycle
         S_RET_RD: begin
            rd_addr  = head_ff;
            state_in = (occ_ff == '0) ? S_DONE : S_RET_CK;
         end
         S_RET_CK: begin
            if (rd_rem_ff == 25'd0) begin
               active_in = (active_ff < rd_size_ff) ? 16'd0 : active_ff - rd_size_ff;
               head_in   = slot_of(head_ff, (OCC_W)'(1));
               occ_in    = occ_ff - 1'b1;
               rd_addr   = slot_of(head_ff, (OCC_W)'(1));
               state_in  = S_RET_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         // one period per cycle
         S_LOOP: begin
            if (tacc_ff >= {1'b0, loop_period_ff}) begin
               tacc_in    = tacc_ff - {1'b0, loop_period_ff};
               pending_in = sat_add16(pending_ff, g);
            end else begin
               timer_in = tacc_ff[23:0];
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            rd_addr = slot_of(head_ff, occ_ff - 1'b1);
            if (pending_ff == 16'd0) begin
               state_in = S_DONE;
            end else if (occ_ff < (OCC_W)'(BATCH_SLOTS)) begin
               wr_en      = 1'b1;
               wr_addr    = slot_of(head_ff, occ_ff);
               wr_rem     = {1'b0, lifetime_ff};
               wr_size    = pending_ff;
               occ_in     = occ_ff + 1'b1;
               active_in  = sat_add16(active_ff, pending_ff);
               granted_in = pending_ff;   // holds the flushed amount
               pending_in = '0;
               state_in   = S_DONE;
            end else begin
               state_in = S_MRG_RD;
            end
         end
         S_MRG_RD: begin
            rd_addr  = slot_of(head_ff, occ_ff - 1'b1);
            state_in = S_MRG_WR;
         end
         S_MRG_WR: begin
            wr_en      = 1'b1;
            wr_addr    = slot_of(head_ff, occ_ff - 1'b1);
            wr_size    = merged;
            wr_rem     = (rd_rem_ff < {1'b0, new_life}) ? {1'b0, new_life} : rd_rem_ff;
            active_in  = sat_add16(active_ff, pending_ff);
            granted_in = pending_ff;
            pending_in = '0;
            state_in   = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in           = 1'b1;
            rsp_in                 = '0;
            rsp_in.active_estimate = active_ff;
            if (mode_ff == MODE_REQUEST) begin
               rsp_in.granted = granted_ff;
            end else if (mode_ff == MODE_FRAME) begin
               rsp_in.emit_now    = (granted_ff != 16'd0);
               rsp_in.emit_amount = granted_ff;
               rsp_in.loop_phase  = (granted_ff != 16'd0) ? 24'd0 : timer_ff;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= '0;
         active_ff    <= '0;
         timer_ff     <= '0;
         elapsed_ff   <= '0;
         occ_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         active_ff    <= active_in;
         timer_ff     <= timer_in;
         elapsed_ff   <= elapsed_in;
         occ_ff       <= occ_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      tacc_ff    <= tacc_in;
      dt_ff      <= dt_in;
      mode_ff    <= mode_in;
      granted_ff <= granted_in;
      rsp_ff     <= rsp_in;
   end

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= (OCC_W)'(BATCH_SLOTS)) else $error("occupancy overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !accept) else $error("accept while busy");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE) else $error("stray result");
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && mode_ff == MODE_FRAME) |-> pending_ff == 16'd0)
      else $error("pending not flushed");

endmodule
